[design/trsq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the timed release sorted queue.
// No dependencies; imported by trsq_cell and timed_release_sorted_queue.
package trsq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_W            = 8;
  localparam int unsigned TIME_W          = 16;
  localparam logic [TIME_W-1:0] TPU_RESET = 16'd100;
  localparam logic [TIME_W-1:0] TIME_MAX  = 16'hFFFF;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_TICK     = 1'b1;
  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] arrival_time;
  } trsq_cmd_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] released_id;
    logic            last;
  } trsq_res_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] due;
  } trsq_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } trsq_op_t;

  typedef struct packed {
    trsq_op_t    op;
    trsq_entry_t entry;
  } trsq_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RELEASE
  } trsq_state_t;

endpackage

[design/trsq_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted queue: holds an entry and moves it to a neighbour.
// Depends on trsq_pkg.
module trsq_cell (
  input  logic                 clk,
  input  trsq_pkg::trsq_ctrl_t ctrl,
  input  logic                 valid,
  input  logic                 left_keep,
  input  trsq_pkg::trsq_entry_t left_entry,
  input  trsq_pkg::trsq_entry_t right_entry,
  output trsq_pkg::trsq_entry_t entry,
  output logic                 keep
);
  import trsq_pkg::*;

  trsq_entry_t entry_next;

  // stays put on insert when its time is equal or earlier (ties keep order)
  assign keep = valid && (entry.due <= ctrl.entry.due);

  always_comb begin
    entry_next = entry;
    unique case (ctrl.op)
      OP_INSERT: begin
        priority if (keep) entry_next = entry;
        else if (left_keep) entry_next = ctrl.entry;
        else entry_next = left_entry;
      end
      OP_POP:  entry_next = right_entry;
      OP_HOLD: entry_next = entry;
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[design/timed_release_sorted_queue.sv]
`timescale 1ns / 1ps
// Top level of the timed release sorted queue: control, prescaler, time
// counter and a row of trsq_cell slots. Depends on trsq_pkg and trsq_cell.
//
//  channel  | signals                    | handshake
//  ---------+----------------------------+--------------------------------
//  command  | start, busy, item          | beat taken when start && !busy
//  result   | strobe, result             | beat valid for one cycle
//  config   | cfg_we, cfg_wdata          | written when cfg_we
//
// Insert: taken without raising busy; a reject appears the next cycle.
// Tick: prescaler and time update first, then the head slot pops one due
// entry per cycle in the release state until none is due; when nothing is
// due, the release state only checks the head and returns to idle.
// Reset clears count, prescaler and time and reloads the divisor; slots need
// no clearing. Results cannot be held off by the receiver.
module timed_release_sorted_queue #(
  parameter int unsigned QUEUE_DEPTH = trsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  trsq_pkg::trsq_cmd_t item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  output logic                strobe,
  output trsq_pkg::trsq_res_t result
);
  import trsq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  trsq_state_t       state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [TIME_W-1:0] prescale, prescale_next;
  logic [TIME_W-1:0] now, now_next;
  logic [TIME_W-1:0] ticks_per_unit;
  logic              strobe_next;
  trsq_res_t         result_next;
  trsq_ctrl_t        ctrl;

  trsq_entry_t             entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  keeps;
  logic [QUEUE_DEPTH-1:0]  valids;

  logic              accept;
  logic [TIME_W:0]   prescale_inc;
  logic              head_due;
  logic              next_due;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign valids[i] = count > CNT_W'(i);
    trsq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (valids[i]),
      .left_keep  ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i-1]),
      .left_entry (entries[(i == 0) ? 0 : i-1]),
      .right_entry(entries[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .entry      (entries[i]),
      .keep       (keeps[i])
    );
  end

  assign busy         = (state != ST_IDLE);
  assign accept       = start && !busy;
  assign prescale_inc = {1'b0, prescale} + {{TIME_W{1'b0}}, 1'b1};
  assign head_due     = valids[0] && (entries[0].due <= now);
  assign next_due     = valids[1] && (entries[1].due <= now);

  always_comb begin
    state_next    = state;
    count_next    = count;
    prescale_next = prescale;
    now_next      = now;
    strobe_next   = 1'b0;
    result_next   = result;
    ctrl.op       = OP_HOLD;
    ctrl.entry    = '{id: item.task_id, due: item.arrival_time};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.command == CMD_INSERT) begin
            if (count == CNT_FULL) begin
              strobe_next = 1'b1;
              result_next = '{kind: KIND_REJECT, released_id: item.task_id, last: 1'b1};
            end else begin
              ctrl.op    = OP_INSERT;
              count_next = count + CNT_W'(1);
            end
          end else begin
            if (prescale_inc >= {1'b0, ticks_per_unit}) begin
              prescale_next = '0;
              if (now != TIME_MAX) now_next = now + TIME_W'(1);
            end else begin
              prescale_next = prescale_inc[TIME_W-1:0];
            end
            state_next = ST_RELEASE;
          end
        end
      end
      ST_RELEASE: begin
        if (head_due) begin
          ctrl.op     = OP_POP;
          count_next  = count - CNT_W'(1);
          strobe_next = 1'b1;
          result_next = '{kind: KIND_RELEASE, released_id: entries[0].id, last: !next_due};
          if (!next_due) state_next = ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      prescale       <= '0;
      now            <= '0;
      ticks_per_unit <= TPU_RESET;
      strobe         <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      prescale <= prescale_next;
      now      <= now_next;
      strobe   <= strobe_next;
      if (cfg_we) ticks_per_unit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    accept && item.command == CMD_INSERT && count == CNT_FULL
    |=> strobe && result.kind == KIND_REJECT && result.last && $stable(count))
    else $error("full insert not rejected");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("non-final beat while idle");

  a_release_due: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == KIND_RELEASE |-> $past(state) == ST_RELEASE)
    else $error("release outside release phase");

endmodule

[tb/timed_release_sorted_queue_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for timed_release_sorted_queue: directed and random
// insert/tick beats checked against a local release-order predictor.
// Depends on trsq_pkg and the design under test.
module timed_release_sorted_queue_tb;
  import trsq_pkg::*;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int STALL_MAX  = 1000;
  localparam int SETTLE     = DEPTH + 4;
  localparam int PHASE_LEN  = 50;

  class release_tracker;
    logic [ID_W-1:0]   ids [DEPTH];
    logic [TIME_W-1:0] dues [DEPTH];
    int                count;
    logic [16:0]       prescale;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] divisor;
    trsq_res_t         due_results [$];
    int                errors;

    function new();
      count    = 0;
      prescale = '0;
      now      = '0;
      divisor  = TPU_RESET;
      errors   = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function void push_result(logic kind, logic [ID_W-1:0] id, logic last);
      trsq_res_t r;
      r.kind        = kind;
      r.released_id = id;
      r.last        = last;
      due_results.push_back(r);
    endfunction

    function void note_beat(trsq_cmd_t c);
      int pos;
      int n;
      if (c.command == CMD_INSERT) begin
        if (count >= DEPTH) begin
          push_result(KIND_REJECT, c.task_id, 1'b1);
          return;
        end
        pos = 0;
        while (pos < count && dues[pos] <= c.arrival_time) pos++;
        for (int j = count; j > pos; j--) begin
          ids[j]  = ids[j-1];
          dues[j] = dues[j-1];
        end
        ids[pos]  = c.task_id;
        dues[pos] = c.arrival_time;
        count++;
        return;
      end
      prescale = prescale + 17'd1;
      if (prescale >= {1'b0, divisor}) begin
        prescale = '0;
        if (now != TIME_MAX) now = now + 1'b1;
      end
      n = 0;
      while (count > 0 && dues[0] <= now && n < DEPTH) begin
        push_result(KIND_RELEASE, ids[0], 1'b0);
        n++;
        for (int j = 0; j < count - 1; j++) begin
          ids[j]  = ids[j+1];
          dues[j] = dues[j+1];
        end
        count--;
      end
      if (n > 0) due_results[$].last = 1'b1;
    endfunction

    task check_result(trsq_res_t r);
      trsq_res_t e;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0b id=%0h last=%0b",
                         r.kind, r.released_id, r.last));
        return;
      end
      e = due_results.pop_front();
      if (r.kind !== e.kind)
        report($sformatf("kind %0b, expected %0b", r.kind, e.kind));
      if (r.released_id !== e.released_id)
        report($sformatf("released_id %0h, expected %0h", r.released_id, e.released_id));
      if (r.last !== e.last)
        report($sformatf("last %0b, expected %0b (id %0h)", r.last, e.last, e.released_id));
    endtask
  endclass

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              busy;
  trsq_cmd_t         item      = '0;
  logic              cfg_we    = 1'b0;
  logic [15:0]       cfg_wdata = '0;
  logic              strobe;
  trsq_res_t         result;

  release_tracker    tracker = new();
  int                stall_cycles = 0;
  bit                no_idle = 1'b0;

  timed_release_sorted_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .strobe    (strobe),
    .result    (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) tracker.check_result(result);
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("timed_release_sorted_queue verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic trsq_cmd_t beat_of(logic cmd, logic [ID_W-1:0] id,
                                        logic [TIME_W-1:0] t);
    trsq_cmd_t c;
    c.command      = cmd;
    c.task_id      = id;
    c.arrival_time = t;
    return c;
  endfunction

  // mostly due soon, some already due, a few anywhere in range
  function automatic logic [TIME_W-1:0] pick_due();
    int unsigned r;
    int unsigned t;
    r = $urandom_range(0, 99);
    if (r < 10) return TIME_W'($urandom);
    if (r < 22) return TIME_W'($urandom_range(0, tracker.now));
    t = tracker.now + $urandom_range(0, 6);
    return (t > TIME_MAX) ? TIME_MAX : TIME_W'(t);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task send(trsq_cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= c;
    do @(posedge clk); while (busy);
    tracker.note_beat(c);
    @(negedge clk);
  endtask

  task drain_results();
    start <= 1'b0;
    while (tracker.due_results.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_divisor(logic [15:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.divisor = v;
  endtask

  task random_phase(logic [15:0] v);
    int fill_left;
    trsq_cmd_t c;
    fill_left = 0;
    write_divisor(v);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < PHASE_LEN; i++) begin
      if ($urandom_range(0, 29) == 0) drain_results();
      if (fill_left == 0 && $urandom_range(0, 39) == 0) fill_left = $urandom_range(12, 20);
      if (fill_left > 0) begin
        fill_left--;
        c = beat_of(CMD_INSERT, ID_W'($urandom), pick_due());
      end else if ($urandom_range(0, 1) == 0) begin
        c = beat_of(CMD_INSERT, ID_W'($urandom), pick_due());
      end else begin
        c = beat_of(CMD_TICK, ID_W'($urandom), TIME_W'($urandom));
      end
      send(c, no_idle ? 0 : $urandom_range(0, 10));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ties at time zero, extremes of id and time
    send(beat_of(CMD_INSERT, 8'h00, 16'h0000), 0);
    send(beat_of(CMD_INSERT, 8'hFF, 16'hFFFF), 1);
    send(beat_of(CMD_INSERT, 8'hA5, 16'h0000), 0);
    send(beat_of(CMD_INSERT, 8'h5A, 16'h0001), 2);
    send(beat_of(CMD_TICK, 8'hFF, 16'hFFFF), 0);
    send(beat_of(CMD_TICK, 8'h00, 16'h0000), 3);
    send(beat_of(CMD_TICK, 8'h00, 16'h0000), 0);
    // divisor dropped under the running prescaler
    write_divisor(16'd2);
    send(beat_of(CMD_TICK, 8'h00, 16'h0000), 0);
    for (int i = 0; i < DEPTH - 1; i++)
      send(beat_of(CMD_INSERT, ID_W'(i + 1), TIME_W'(2 + i % 4)), i % 3);
    send(beat_of(CMD_INSERT, 8'h3C, 16'h0000), 0);

    random_phase(16'd1);
    random_phase(16'd3);
    random_phase(16'hFFFF);
    random_phase(16'd2);
    random_phase(TPU_RESET);
    random_phase(16'd0);

    // late due times at the top of the range, then closing ticks
    send(beat_of(CMD_TICK, 8'h00, 16'h0000), 0);
    send(beat_of(CMD_INSERT, 8'h11, 16'hFFFF), 0);
    send(beat_of(CMD_INSERT, 8'h22, 16'hFFFE), 2);
    send(beat_of(CMD_TICK, 8'h00, 16'h0000), 0);
    send(beat_of(CMD_TICK, 8'h00, 16'h0000), 1);

    start <= 1'b0;
    while (tracker.due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (tracker.due_results.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.due_results.size()));
    if (tracker.errors == 0) begin
      $display("timed_release_sorted_queue verification clean");
    end else begin
      $display("timed_release_sorted_queue verification failed");
    end
    $finish;
  end

endmodule
